// ===== src/mrm2h_pkg.sv =====
// ----------------------------------------------------------------------------
// mrm2h_pkg
// Shared constants, types and helpers of the MurmurHash2 string hash unit.
// ----------------------------------------------------------------------------
package mrm2h_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned CountW = 3;
    localparam int unsigned LenW   = 16;

    localparam logic [WordW-1:0] MixMul    = 32'h5bd1_e995;
    localparam int unsigned      MixShift  = 24;
    localparam int unsigned      FinShiftA = 13;
    localparam int unsigned      FinShiftB = 15;
    localparam logic [WordW-1:0] SeedReset = 32'd97;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_HMIX,
        ST_TAIL,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_K1,
        OP_K2,
        OP_HMIX,
        OP_TAIL,
        OP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   seed;
    } t_dp_cmd;

    typedef struct packed {
        logic in_full;
        logic in_tail;
        logic in_last;
        logic last;
        logic out_free;
    } t_dp_sts;

    // Keeps the valid low bytes of a short tail word.
    function automatic logic [WordW-1:0] tail_mask(input logic [1:0] cnt);
        logic [WordW-1:0] m;
        unique case (cnt)
            2'd3:    m = 32'h00ff_ffff;
            2'd2:    m = 32'h0000_ffff;
            2'd1:    m = 32'h0000_00ff;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== src/mrm2h_in_if.sv =====
// ----------------------------------------------------------------------------
// mrm2h_in_if
// Input channel: one string word per item with its byte count, last flag
// and the total string length.
// ----------------------------------------------------------------------------
interface mrm2h_in_if;
    logic                            valid;
    logic                            ready;
    logic [mrm2h_pkg::WordW-1:0]     data_word;
    logic [mrm2h_pkg::CountW-1:0]    byte_count;
    logic                            is_last;
    logic [mrm2h_pkg::LenW-1:0]      total_len;

    modport source (output valid, data_word, byte_count, is_last, total_len,
                    input ready);
    modport sink   (input valid, data_word, byte_count, is_last, total_len,
                    output ready);
endinterface

// ===== src/mrm2h_out_if.sv =====
// ----------------------------------------------------------------------------
// mrm2h_out_if
// Output channel: one finished hash per item.
// ----------------------------------------------------------------------------
interface mrm2h_out_if;
    logic                        valid;
    logic                        ready;
    logic [mrm2h_pkg::WordW-1:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

// ===== src/mrm2h_datapath.sv =====
// ----------------------------------------------------------------------------
// mrm2h_datapath
// Hash registers, the shared constant multiplier and the output register.
// ----------------------------------------------------------------------------
module mrm2h_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mrm2h_pkg::WordW-1:0]  i_cfg_wdata,
    input  mrm2h_pkg::t_dp_cmd           i_cmd,
    output mrm2h_pkg::t_dp_sts           o_sts,
    mrm2h_in_if.sink                     i_in,
    mrm2h_out_if.source                  o_out
);
    import mrm2h_pkg::*;

    logic [WordW-1:0] r_seed;
    logic [WordW-1:0] r_hash;
    logic [WordW-1:0] r_k;
    logic [WordW-1:0] r_word;
    logic [1:0]       r_cnt;
    logic             r_last;
    logic [WordW-1:0] r_out;
    logic             r_out_valid;

    logic [WordW-1:0] mul_a;
    logic [WordW-1:0] prod;
    logic [WordW-1:0] seeded;

    assign seeded = r_seed ^ {{(WordW-LenW){1'b0}}, i_in.total_len};

    always_comb begin
        unique case (i_cmd.op)
            OP_K1:   mul_a = r_word;
            OP_K2:   mul_a = r_k ^ (r_k >> MixShift);
            OP_HMIX: mul_a = r_hash;
            OP_TAIL: mul_a = r_hash ^ (r_word & tail_mask(r_cnt));
            OP_FIN:  mul_a = r_hash ^ (r_hash >> FinShiftA);
            default: mul_a = r_hash;
        endcase
    end

    // Only the low half of the product is kept.
    assign prod = mul_a * MixMul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= SeedReset;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cmd.op == OP_FIN) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_word <= i_in.data_word;
                r_cnt  <= i_in.byte_count[1:0];
                r_last <= i_in.is_last;
                if (i_cmd.seed) begin
                    r_hash <= seeded;
                end
            end
            OP_K1, OP_K2: begin
                r_k <= prod;
            end
            OP_HMIX: begin
                r_hash <= prod ^ r_k;
            end
            OP_TAIL: begin
                r_hash <= prod;
            end
            OP_FIN: begin
                r_out <= prod ^ (prod >> FinShiftB);
            end
            default: begin
            end
        endcase
    end

    // Counts of four and above are taken as a full word.
    assign o_sts.in_full  = i_in.byte_count[2];
    assign o_sts.in_tail  = !i_in.byte_count[2] && (i_in.byte_count[1:0] != 2'd0);
    assign o_sts.in_last  = i_in.is_last;
    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out;
endmodule

// ===== src/mrm2h_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrm2h_ctrl
// Sequencer that walks each item through the steps of the shared multiplier.
// ----------------------------------------------------------------------------
module mrm2h_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mrm2h_pkg::t_dp_sts i_sts,
    output mrm2h_pkg::t_dp_cmd o_cmd
);
    import mrm2h_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_in_msg;
    logic   n_in_msg;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_in_msg <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_msg <= n_in_msg;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_in_msg = r_in_msg;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_in_msg = 1'b1;
                    priority if (i_sts.in_full) begin
                        n_state = ST_K1;
                    end else if (i_sts.in_tail) begin
                        n_state = ST_TAIL;
                    end else if (i_sts.in_last) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_K1:   n_state = ST_K2;
            ST_K2:   n_state = ST_HMIX;
            ST_HMIX, ST_TAIL: begin
                n_state = i_sts.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                // Waits here while the previous hash is still unread.
                if (i_sts.out_free) begin
                    n_state  = ST_IDLE;
                    n_in_msg = 1'b0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.seed = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.op   = OP_LOAD;
                    o_cmd.seed = !r_in_msg;
                end
            end
            ST_K1:   o_cmd.op = OP_K1;
            ST_K2:   o_cmd.op = OP_K2;
            ST_HMIX: o_cmd.op = OP_HMIX;
            ST_TAIL: o_cmd.op = OP_TAIL;
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_FIN;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end
endmodule

// ===== src/murmur2_string_hash_unit.sv =====
// ----------------------------------------------------------------------------
// murmur2_string_hash_unit
// 32-bit MurmurHash2 over a byte string delivered as little-endian words.
// ----------------------------------------------------------------------------
// The unit takes one word per item and returns one hash on the item marked
// last. A single 32-bit constant multiplier is shared by all steps, one
// multiply per cycle: a full four-byte word is accepted and then takes
// three multiplies (K1, K2, HMIX), a short tail word takes one (TAIL), an
// empty word takes none, and the last item adds the final avalanche. The
// finished hash sits in an output register, so the next string may start
// while it waits; the avalanche step stalls only if the previous hash has
// not yet been taken. The seed register may be written whenever no item is
// in progress and takes effect on the first word of the next string.
module murmur2_string_hash_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mrm2h_pkg::WordW-1:0]  i_cfg_wdata,
    mrm2h_in_if.sink                     i_in,
    mrm2h_out_if.source                  o_out
);
    import mrm2h_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mrm2h_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mrm2h_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .o_out       (o_out)
    );
endmodule
